>>> rtl/core/assert_macros.svh
// Assertion macros shared by the solver RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define CLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define CLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cls_pkg.sv
// Types, codes and fixed-point helpers of the Cholesky solver
package cls_pkg;

    localparam int DATA_W            = 64;
    localparam int ORDER_W           = 5;
    localparam int DEFAULT_MAX_ORDER = 16;
    localparam int APB_ADDR_W        = 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic        [DATA_W-1:0] mag_t;

    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_GO     = 2'd2;

    localparam logic REG_ORDER = 1'b0;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    function automatic mag_t magnitude(input data_t v);
        return v[DATA_W-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    function automatic data_t signed_sat(input logic neg, input mag_t m);
        data_t r;
        if (!neg) begin
            r = m[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : data_t'(m);
        end else if (m[DATA_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = -data_t'(m);
        end
        return r;
    endfunction

    function automatic data_t sat_sub(input data_t a, input data_t b);
        data_t d;
        d = a - b;
        if ((a[DATA_W-1] != b[DATA_W-1]) && (d[DATA_W-1] != a[DATA_W-1])) begin
            d = a[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return d;
    endfunction

endpackage

>>> rtl/core/cls_ram.sv
// Generic single-write, single-read RAM with registered read data
module cls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/cholesky_linear_solver_core.sv
// Cholesky linear solver: top level with sequencer and shared arithmetic unit
//
// Loads of matrix and right-hand entries are taken one per cycle while the
// block is idle. A go request factors A = L*L^T, runs forward and back
// substitution and returns n results, one per solution element, each held
// until m_ready is high. Values are signed Q31.32. All arithmetic runs on one
// shared unit: a 32x32 multiplier that builds each 64x64 product from 32x32
// partial products, a restoring divider at one quotient bit per cycle and a
// square root at one root bit per cycle. The block takes no request from the
// go until its last result is delivered. A non-positive pivot stops the
// factorization early and all results carry value zero and status one.
// The stores need no clearing after reset.
module cholesky_linear_solver_core #(
    parameter int MAX_ORDER = cls_pkg::DEFAULT_MAX_ORDER
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cls_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [3:0]                    s_row,
    input  logic [3:0]                    s_col,
    input  cls_pkg::data_t                s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_index,
    output cls_pkg::data_t                m_solution_value,
    output logic                          m_last,
    output logic                          m_status
);

    import cls_pkg::*;

    localparam int IDX_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int MDEPTH  = MAX_ORDER * MAX_ORDER;
    localparam int MADDR_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam int CNT_W   = $clog2(MAX_ORDER + 1);
    localparam int OW      = (CNT_W > ORDER_W) ? CNT_W : ORDER_W;
    localparam int LW      = (CNT_W > 4) ? CNT_W : 4;
    localparam int SH_W    = DATA_W + 32;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_INIT     = 5'd1;
    localparam logic [4:0] S_INIT_CAP = 5'd2;
    localparam logic [4:0] S_P_RD     = 5'd3;
    localparam logic [4:0] S_Q_RD     = 5'd4;
    localparam logic [4:0] S_MUL_LD   = 5'd5;
    localparam logic [4:0] S_MUL      = 5'd6;
    localparam logic [4:0] S_MUL_FIN  = 5'd7;
    localparam logic [4:0] S_SUB      = 5'd8;
    localparam logic [4:0] S_D_RD     = 5'd9;
    localparam logic [4:0] S_DIV_LD   = 5'd10;
    localparam logic [4:0] S_DIV      = 5'd11;
    localparam logic [4:0] S_SQRT     = 5'd12;
    localparam logic [4:0] S_WRITE    = 5'd13;
    localparam logic [4:0] S_OUT_RD   = 5'd14;
    localparam logic [4:0] S_OUT_LD   = 5'd15;
    localparam logic [4:0] S_OUT_WAIT = 5'd16;

    localparam logic [1:0] PH_FACT = 2'd0;
    localparam logic [1:0] PH_FWD  = 2'd1;
    localparam logic [1:0] PH_BWD  = 2'd2;

    localparam logic [6:0] DIV_LAST  = 7'(SH_W - 1);
    localparam logic [6:0] SQRT_LAST = 7'(SH_W / 2 - 1);

    logic [4:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [CNT_W-1:0]    i_reg, i_next, j_reg, j_next, k_reg, k_next, n_reg, n_next;
    data_t               e_reg, e_next, prod_reg, prod_next;
    mag_t                ma_reg, ma_next, mb_reg, mb_next, den_reg, den_next;
    mag_t                rem_reg, rem_next, q_reg, q_next;
    logic                sa_reg, sa_next, neg_reg, neg_next, over_reg, over_next;
    logic [127:0]        acc_reg, acc_next;
    logic [SH_W-1:0]     sh_reg, sh_next;
    logic [6:0]          step_reg, step_next;
    logic                err_reg, err_next;
    logic [ORDER_W-1:0]  order_reg, order_next;
    logic                m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic                m_status_reg, m_status_next;
    logic [3:0]          m_index_reg, m_index_next;
    data_t               m_value_reg, m_value_next;

    logic                a_we, b_we, l_we, v_we;
    logic [MADDR_W-1:0]  a_waddr, a_raddr, l_waddr, l_raddr;
    logic [IDX_W-1:0]    b_waddr, b_raddr, v_waddr, v_raddr;
    data_t               a_rdata, b_rdata, l_rdata, v_rdata, res;

    logic [LW-1:0]       row_l, col_l;
    logic                row_ok, col_ok;
    logic [OW-1:0]       ord_ext;
    logic [CNT_W-1:0]    n_clamp, kend, kstart, k_inc, i_inc;
    logic [LW-1:0]       i_wide;
    logic [63:0]         pp;
    logic [127:0]        pp_sh;
    logic [64:0]         rem_w;
    logic                div_ge, sqrt_ge, diag;
    mag_t                rem_s, trial, mul_m;
    data_t               q_data;

    function automatic logic [MADDR_W-1:0] mat(input logic [CNT_W-1:0] r,
                                               input logic [CNT_W-1:0] c);
        return MADDR_W'(r[IDX_W-1:0]) * MADDR_W'(MAX_ORDER) + MADDR_W'(c[IDX_W-1:0]);
    endfunction

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ORDER) ? {{(32-ORDER_W){1'b0}}, order_reg} : 32'd0;

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_index          = m_index_reg;
    assign m_solution_value = m_value_reg;
    assign m_last           = m_last_reg;
    assign m_status         = m_status_reg;

    assign row_l   = LW'(s_row);
    assign col_l   = LW'(s_col);
    assign row_ok  = row_l < LW'(MAX_ORDER);
    assign col_ok  = (col_l < LW'(MAX_ORDER)) && (s_col <= s_row);
    assign ord_ext = OW'(order_reg);
    assign n_clamp = (ord_ext == '0) ? CNT_W'(1) :
                     (ord_ext > OW'(MAX_ORDER)) ? CNT_W'(MAX_ORDER) : CNT_W'(ord_ext);

    assign a_we    = s_valid && s_ready && (s_req_type == REQ_LOAD_A) && row_ok && col_ok;
    assign a_waddr = MADDR_W'(row_l[IDX_W-1:0]) * MADDR_W'(MAX_ORDER)
                   + MADDR_W'(col_l[IDX_W-1:0]);
    assign b_we    = s_valid && s_ready && (s_req_type == REQ_LOAD_B) && row_ok;
    assign b_waddr = row_l[IDX_W-1:0];

    assign diag    = (phase_reg == PH_FACT) && (j_reg == i_reg);
    assign a_raddr = mat(i_reg, j_reg);
    assign b_raddr = i_reg[IDX_W-1:0];
    assign v_raddr = (state_reg == S_Q_RD) ? k_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
    assign l_we    = (state_reg == S_WRITE) && (phase_reg == PH_FACT);
    assign l_waddr = mat(i_reg, j_reg);
    assign v_we    = (state_reg == S_WRITE) && (phase_reg != PH_FACT);
    assign v_waddr = i_reg[IDX_W-1:0];

    always_comb begin
        case (state_reg)
            S_P_RD:  l_raddr = (phase_reg == PH_BWD) ? mat(k_reg, i_reg) : mat(i_reg, k_reg);
            S_Q_RD:  l_raddr = mat(j_reg, k_reg);
            S_D_RD:  l_raddr = (phase_reg == PH_FACT) ? mat(j_reg, j_reg) : mat(i_reg, i_reg);
            default: l_raddr = '0;
        endcase
    end

    cls_ram #(.WIDTH(DATA_W), .DEPTH(MDEPTH)) u_a_ram (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(s_value),
        .raddr(a_raddr), .rdata(a_rdata)
    );
    cls_ram #(.WIDTH(DATA_W), .DEPTH(MDEPTH)) u_l_ram (
        .aclk(aclk), .we(l_we), .waddr(l_waddr), .wdata(res),
        .raddr(l_raddr), .rdata(l_rdata)
    );
    cls_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ORDER)) u_b_ram (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(s_value),
        .raddr(b_raddr), .rdata(b_rdata)
    );
    cls_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ORDER)) u_v_ram (
        .aclk(aclk), .we(v_we), .waddr(v_waddr), .wdata(res),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    // loop bounds of the current sum
    always_comb begin
        case (phase_reg)
            PH_FACT: kend = j_reg;
            PH_FWD:  kend = i_reg;
            default: kend = n_reg;
        endcase
    end
    assign kstart = (phase_reg == PH_BWD) ? i_reg + CNT_W'(1) : '0;
    assign k_inc  = k_reg + CNT_W'(1);
    assign i_inc  = i_reg + CNT_W'(1);
    assign i_wide = LW'(i_reg);

    // shared unit: partial products, divider step, root step
    always_comb begin
        pp = {32'd0, step_reg[1] ? ma_reg[63:32] : ma_reg[31:0]}
           * {32'd0, step_reg[0] ? mb_reg[63:32] : mb_reg[31:0]};
        case (step_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    assign mul_m  = acc_reg[95:32] + mag_t'(neg_reg && (acc_reg[31:0] != '0));
    assign rem_w  = {rem_reg, sh_reg[SH_W-1]};
    assign div_ge = rem_w >= {1'b0, den_reg};
    assign rem_s  = {rem_reg[61:0], sh_reg[SH_W-1 -: 2]};
    assign trial  = {14'd0, q_reg[47:0], 2'b01};
    assign sqrt_ge = rem_s >= trial;
    assign q_data = data_t'(q_reg);
    assign res    = diag ? q_data :
                    (den_reg == '0) ? '0 : signed_sat(neg_reg, over_reg ? '1 : q_reg);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        e_next        = e_reg;
        prod_next     = prod_reg;
        ma_next       = ma_reg;
        mb_next       = mb_reg;
        sa_next       = sa_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        den_next      = den_reg;
        sh_next       = sh_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        over_next     = over_reg;
        step_next     = step_reg;
        err_next      = err_reg;
        order_next    = order_reg;
        m_valid_next  = m_valid_reg;
        m_index_next  = m_index_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;

        if (psel && penable && pwrite && pready && (paddr[2] == REG_ORDER)) begin
            order_next = pwdata[ORDER_W-1:0];
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && (s_req_type == REQ_GO)) begin
                    n_next     = n_clamp;
                    i_next     = '0;
                    j_next     = '0;
                    phase_next = PH_FACT;
                    err_next   = 1'b0;
                    state_next = S_INIT;
                end
            end
            S_INIT: state_next = S_INIT_CAP;
            S_INIT_CAP: begin
                case (phase_reg)
                    PH_FACT: e_next = a_rdata;
                    PH_FWD:  e_next = b_rdata;
                    default: e_next = v_rdata;
                endcase
                k_next     = kstart;
                state_next = (kstart < kend) ? S_P_RD : S_D_RD;
            end
            S_P_RD: state_next = S_Q_RD;
            S_Q_RD: begin
                ma_next    = magnitude(l_rdata);
                sa_next    = l_rdata[DATA_W-1];
                state_next = S_MUL_LD;
            end
            S_MUL_LD: begin
                if (phase_reg == PH_FACT) begin
                    mb_next  = magnitude(l_rdata);
                    neg_next = sa_reg ^ l_rdata[DATA_W-1];
                end else begin
                    mb_next  = magnitude(v_rdata);
                    neg_next = sa_reg ^ v_rdata[DATA_W-1];
                end
                acc_next   = '0;
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                acc_next  = acc_reg + pp_sh;
                step_next = step_reg + 7'd1;
                if (step_reg[1:0] == 2'd3) begin
                    state_next = S_MUL_FIN;
                end
            end
            S_MUL_FIN: begin
                prod_next  = (acc_reg[127:95] != '0) ? signed_sat(neg_reg, '1)
                                                     : signed_sat(neg_reg, mul_m);
                state_next = S_SUB;
            end
            S_SUB: begin
                e_next     = sat_sub(e_reg, prod_reg);
                k_next     = k_inc;
                state_next = (k_inc < kend) ? S_P_RD : S_D_RD;
            end
            S_D_RD: begin
                if (diag) begin
                    if (e_reg[DATA_W-1] || (e_reg == '0)) begin
                        err_next   = 1'b1;
                        i_next     = '0;
                        state_next = S_OUT_RD;
                    end else begin
                        sh_next    = {e_reg, 32'd0};
                        rem_next   = '0;
                        q_next     = '0;
                        step_next  = '0;
                        state_next = S_SQRT;
                    end
                end else begin
                    state_next = S_DIV_LD;
                end
            end
            S_DIV_LD: begin
                den_next   = magnitude(l_rdata);
                neg_next   = e_reg[DATA_W-1] ^ l_rdata[DATA_W-1];
                sh_next    = {magnitude(e_reg), 32'd0};
                rem_next   = '0;
                q_next     = '0;
                over_next  = 1'b0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next  = div_ge ? rem_w[63:0] - den_reg : rem_w[63:0];
                q_next    = {q_reg[62:0], div_ge};
                over_next = over_reg | q_reg[63];
                sh_next   = sh_reg << 1;
                step_next = step_reg + 7'd1;
                if (step_reg == DIV_LAST) begin
                    state_next = S_WRITE;
                end
            end
            S_SQRT: begin
                rem_next  = sqrt_ge ? rem_s - trial : rem_s;
                q_next    = {q_reg[62:0], sqrt_ge};
                sh_next   = sh_reg << 2;
                step_next = step_reg + 7'd1;
                if (step_reg == SQRT_LAST) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                state_next = S_INIT;
                case (phase_reg)
                    PH_FACT: begin
                        if (!diag) begin
                            j_next = j_reg + CNT_W'(1);
                        end else if (i_inc == n_reg) begin
                            phase_next = PH_FWD;
                            i_next     = '0;
                        end else begin
                            i_next = i_inc;
                            j_next = '0;
                        end
                    end
                    PH_FWD: begin
                        if (i_inc == n_reg) begin
                            phase_next = PH_BWD;
                            i_next     = n_reg - CNT_W'(1);
                        end else begin
                            i_next = i_inc;
                        end
                    end
                    default: begin
                        if (i_reg == '0) begin
                            state_next = S_OUT_RD;
                        end else begin
                            i_next = i_reg - CNT_W'(1);
                        end
                    end
                endcase
            end
            S_OUT_RD: state_next = S_OUT_LD;
            S_OUT_LD: begin
                m_valid_next  = 1'b1;
                m_index_next  = i_wide[3:0];
                m_value_next  = err_reg ? '0 : v_rdata;
                m_last_next   = (i_inc == n_reg);
                m_status_next = err_reg ? STATUS_ERR : STATUS_OK;
                state_next    = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_inc;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_FACT;
            err_reg     <= 1'b0;
            order_reg   <= ORDER_W'(16);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            err_reg     <= err_next;
            order_reg   <= order_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        e_reg        <= e_next;
        prod_reg     <= prod_next;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        sa_reg       <= sa_next;
        neg_reg      <= neg_next;
        acc_reg      <= acc_next;
        den_reg      <= den_next;
        sh_reg       <= sh_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        over_reg     <= over_next;
        step_reg     <= step_next;
        m_index_reg  <= m_index_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

`include "assert_macros.svh"

    `CLS_ASSERT_NOW(a_no_accept_while_result, m_valid_reg, !s_ready, "request taken with result pending")
    `CLS_ASSERT_NOW(a_error_value_zero, m_valid_reg && m_status_reg, m_value_reg == '0, "error result has nonzero value")
    `CLS_ASSERT_NEXT(a_last_returns_idle, m_valid_reg && m_ready && m_last_reg, s_ready, "no idle after last result")
    `CLS_ASSERT_NEXT(a_mul_four_cycles, (state_reg == S_MUL) && (step_reg[1:0] == 2'd3), state_reg == S_MUL_FIN, "product not finished after four partial products")

endmodule
